// ===== src/assert_macros.svh =====
// Assertion macros shared by the loop layer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/lrp_pkg.sv =====
// Types, codes and arithmetic constants of the loop record/play layer.
package lrp_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WORD_W      = 2 * SAMPLE_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int GAIN_SH     = 14;
    localparam int OP_W        = 3;
    localparam int SRC_W       = 2;
    localparam int SPEED_W     = 18;
    localparam int GAIN_W      = 16;
    localparam int PAN_W       = 17;

    // Shared multiplier: signed operand times unsigned coefficient.
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 17;
    localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;

    localparam logic [MUL_B_W-1:0] UNITY = MUL_B_W'(2 ** FRAC_BITS);

    localparam logic signed [ACC_W-1:0] BIAS_FRAC = ACC_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] BIAS_GAIN = ACC_W'(2 ** (GAIN_SH - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);

    localparam logic [OP_W-1:0] OP_FRAME     = 3'd0;
    localparam logic [OP_W-1:0] OP_REC_START = 3'd1;
    localparam logic [OP_W-1:0] OP_REC_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [SRC_W-1:0] SRC_RIGHT = 2'd0;
    localparam logic [SRC_W-1:0] SRC_LEFT  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REC_R,
        ST_REC_DONE,
        ST_RD1,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_WRAP_ADD,
        ST_WRAP_SUB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic en;        // load the accumulator
        logic accum;     // add to previous sum instead of rounding bias
        logic rnd_gain;  // bias for a Q2.14 gain shift, else for a 16-bit shift
    } t_mac_cmd;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/lrp_in_if.sv =====
// Request channel carrying one frame or control event.
interface lrp_in_if import lrp_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               op;
    logic signed [SAMPLE_BITS-1:0] mic_sample;
    logic signed [SAMPLE_BITS-1:0] guitar_sample;
    logic [SRC_W-1:0]              source_sel;
    logic [SPEED_W-1:0]            speed;
    logic [GAIN_W-1:0]             gain;
    logic [PAN_W-1:0]              pan;

    modport source (
        output valid, op, mic_sample, guitar_sample, source_sel, speed, gain, pan,
        input  ready
    );
    modport sink (
        input  valid, op, mic_sample, guitar_sample, source_sel, speed, gain, pan,
        output ready
    );
endinterface

// ===== src/lrp_out_if.sv =====
// Result channel carrying the layer's stereo contribution and status flags.
interface lrp_out_if import lrp_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          is_recording;
    logic                          has_loop;
    logic                          is_paused;

    modport source (
        output valid, left_out, right_out, is_recording, has_loop, is_paused,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, is_recording, has_loop, is_paused,
        output ready
    );
endinterface

// ===== src/lrp_mem.sv =====
// Loop store: one write port, one read port, registered read data.
module lrp_mem import lrp_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lrp_mac.sv =====
// Shared multiply-accumulate unit with round-half-up bias injection.
module lrp_mac import lrp_pkg::*; (
    input  logic                      i_clk,
    input  t_mac_cmd                  i_cmd,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0]        i_b,
    output logic signed [ACC_W-1:0]   o_acc
);

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] r_acc;

    assign prod   = i_a * $signed({1'b0, i_b});
    assign addend = i_cmd.accum ? r_acc : (i_cmd.rnd_gain ? BIAS_GAIN : BIAS_FRAC);

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= prod + addend;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== src/loop_record_play_layer.sv =====
// Top level of the loop record/play layer: sequencer, position logic and flags.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------------
//  i_in    | in  | valid/ready         | op, mic/guitar sample, source, speed, gain, pan
//  o_out   | out | valid/ready         | left/right out, recording, loop, paused flags
//
// One request at a time. Control events and idle frames pass from accept through decode to
// the output step, recorded frames add a gain pass per channel, and played frames take the
// longest: the single multiplier runs 8 passes per played frame, the one read port fetches
// both neighbors in turn, and the position wrap subtracts the loop span up to four times.
// Sync active-low reset clears flags, counters and position; store entries stay undefined.
// A held result in o_out does not block the next accept, only the next result load.
`include "assert_macros.svh"

module loop_record_play_layer import lrp_pkg::*; #(
    parameter int BUFFER_DEPTH = 262144
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lrp_in_if.sink  i_in,
    lrp_out_if.source o_out
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    // position < span plus one speed step before the wrap
    localparam int POS_W  = CNT_W + FRAC_BITS + 1;

    // ---------------------------------------------------------------------
    // Captured request
    // ---------------------------------------------------------------------
    logic                          in_acc;
    logic [OP_W-1:0]               r_op;
    logic signed [SAMPLE_BITS-1:0] r_mic;
    logic signed [SAMPLE_BITS-1:0] r_gtr;
    logic [SRC_W-1:0]              r_src;
    logic [SPEED_W-1:0]            r_speed;
    logic [GAIN_W-1:0]             r_gain;
    logic [PAN_W-1:0]              r_pan;
    logic [PAN_W-1:0]              pan_sat;

    // ---------------------------------------------------------------------
    // Layer state
    // ---------------------------------------------------------------------
    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_len, n_len;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic                          r_rec, n_rec;
    logic                          r_valid, n_valid;
    logic                          r_paused, n_paused;
    logic [WORD_W-1:0]             r_s0, n_s0;
    logic signed [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic signed [SAMPLE_BITS-1:0] r_ro, n_ro;

    // Output register
    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_oleft, r_oright;
    logic                          r_orec, r_oloop, r_opause;
    logic                          out_load;

    // Datapath hookup
    t_mac_cmd                      mac_cmd;
    logic signed [MUL_A_W-1:0]     mac_a;
    logic [MUL_B_W-1:0]            mac_b;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_r16;
    logic signed [ACC_W-1:0]       acc_r14;

    logic                          mem_we, mem_re;
    logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
    logic [WORD_W-1:0]             mem_wdata, mem_rdata;

    logic signed [SAMPLE_BITS-1:0] sl, sr;
    logic signed [SAMPLE_BITS-1:0] rd_l, rd_r, s0_l, s0_r;
    logic [ADDR_W-1:0]             i0, i1;
    logic [CNT_W-1:0]              i1_n;
    logic [MUL_B_W-1:0]            frac, ufrac, lpan;
    logic [POS_W-1:0]              span;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign pan_sat    = (i_in.pan > UNITY) ? UNITY : i_in.pan;

    // request capture, payload only
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_in.op;
            r_mic   <= i_in.mic_sample;
            r_gtr   <= i_in.guitar_sample;
            r_src   <= i_in.source_sel;
            r_speed <= i_in.speed;
            r_gain  <= i_in.gain;
            r_pan   <= pan_sat;
        end
    end

    // source routing; codes two and three both mean true stereo
    always_comb begin
        case (r_src)
            SRC_RIGHT: begin
                sl = r_gtr;
                sr = r_gtr;
            end
            SRC_LEFT: begin
                sl = r_mic;
                sr = r_mic;
            end
            default: begin
                sl = r_mic;
                sr = r_gtr;
            end
        endcase
    end

    // store word is {left, right}
    assign rd_l = $signed(mem_rdata[WORD_W-1 -: SAMPLE_BITS]);
    assign rd_r = $signed(mem_rdata[SAMPLE_BITS-1:0]);
    assign s0_l = $signed(r_s0[WORD_W-1 -: SAMPLE_BITS]);
    assign s0_r = $signed(r_s0[SAMPLE_BITS-1:0]);

    // read position: integer part indexes the store, low bits weight the pair
    assign i0    = r_pos[FRAC_BITS +: ADDR_W];
    assign i1_n  = CNT_W'(i0) + CNT_W'(1);
    assign i1    = (i1_n >= r_len) ? '0 : i1_n[ADDR_W-1:0];
    assign frac  = {1'b0, r_pos[FRAC_BITS-1:0]};
    assign ufrac = UNITY - frac;
    assign lpan  = UNITY - r_pan;
    assign span  = POS_W'(r_len) << FRAC_BITS;

    // rounded views of the accumulator; bias was added with the product
    assign acc_r16 = acc >>> FRAC_BITS;
    assign acc_r14 = acc >>> GAIN_SH;

    assign mem_waddr = r_cnt[ADDR_W-1:0];
    assign mem_wdata = {sl, sr};

    lrp_mem #(
        .DEPTH   (BUFFER_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lrp_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (mac_cmd),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_rec    <= 1'b0;
            r_valid  <= 1'b0;
            r_paused <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_rec    <= n_rec;
            r_valid  <= n_valid;
            r_paused <= n_paused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_lo <= n_lo;
        r_ro <= n_ro;
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_rec     = r_rec;
        n_valid   = r_valid;
        n_paused  = r_paused;
        n_s0      = r_s0;
        n_lo      = r_lo;
        n_ro      = r_ro;
        mac_cmd   = '0;
        mac_a     = '0;
        mac_b     = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = i0;
        out_load  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_lo    = '0;
                n_ro    = '0;
                n_state = ST_OUT;
                unique case (r_op)
                    OP_FRAME: begin
                        if (r_rec) begin
                            // store until full, pass through regardless
                            if (r_cnt < CNT_W'(BUFFER_DEPTH)) begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + CNT_W'(1);
                            end
                            mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b1};
                            mac_a   = MUL_A_W'(sl);
                            mac_b   = MUL_B_W'(r_gain);
                            n_state = ST_REC_R;
                        end else if (r_valid && !r_paused) begin
                            mem_re    = 1'b1;
                            mem_raddr = i0;
                            n_state   = ST_RD1;
                        end
                    end
                    OP_REC_START: begin
                        if (!r_rec) begin
                            n_rec    = 1'b1;
                            n_cnt    = '0;
                            n_valid  = 1'b0;
                            n_paused = 1'b0;
                        end
                    end
                    OP_REC_STOP: begin
                        if (r_rec) begin
                            n_rec   = 1'b0;
                            n_len   = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
                            n_pos   = '0;
                            n_valid = 1'b1;
                        end
                    end
                    OP_PAUSE: begin
                        if (!r_rec && r_valid) begin
                            n_paused = !r_paused;
                        end
                    end
                    OP_CLEAR: begin
                        if (!r_rec) begin
                            n_valid  = 1'b0;
                            n_len    = '0;
                            n_pos    = '0;
                            n_paused = 1'b0;
                        end
                    end
                    default: ;  // unused op codes answer like a control event
                endcase
            end

            ST_REC_R: begin
                n_lo    = sat_sample(acc_r14);
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b1};
                mac_a   = MUL_A_W'(sr);
                mac_b   = MUL_B_W'(r_gain);
                n_state = ST_REC_DONE;
            end

            ST_REC_DONE: begin
                n_ro    = sat_sample(acc_r14);
                n_state = ST_OUT;
            end

            // s[i0] lands now, fetch s[i1]
            ST_RD1: begin
                n_s0      = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = i1;
                n_state   = ST_M1;
            end

            // left: interpolate, gain, pan
            ST_M1: begin
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(s0_l);
                mac_b   = ufrac;
                n_state = ST_M2;
            end
            ST_M2: begin
                mac_cmd = '{en: 1'b1, accum: 1'b1, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(rd_l);
                mac_b   = frac;
                n_state = ST_M3;
            end
            ST_M3: begin
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b1};
                mac_a   = MUL_A_W'(acc_r16);
                mac_b   = MUL_B_W'(r_gain);
                n_state = ST_M4;
            end
            ST_M4: begin
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(acc_r14);
                mac_b   = lpan;
                n_state = ST_M5;
            end

            // right channel, same chain with the pan share itself
            ST_M5: begin
                n_lo    = sat_sample(acc_r16);
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(s0_r);
                mac_b   = ufrac;
                n_state = ST_M6;
            end
            ST_M6: begin
                mac_cmd = '{en: 1'b1, accum: 1'b1, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(rd_r);
                mac_b   = frac;
                n_state = ST_M7;
            end
            ST_M7: begin
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b1};
                mac_a   = MUL_A_W'(acc_r16);
                mac_b   = MUL_B_W'(r_gain);
                n_state = ST_M8;
            end
            ST_M8: begin
                mac_cmd = '{en: 1'b1, accum: 1'b0, rnd_gain: 1'b0};
                mac_a   = MUL_A_W'(acc_r14);
                mac_b   = r_pan;
                n_state = ST_WRAP_ADD;
            end

            ST_WRAP_ADD: begin
                n_ro    = sat_sample(acc_r16);
                n_pos   = r_pos + POS_W'(r_speed);
                n_state = ST_WRAP_SUB;
            end

            // speed is below four spans, so the span is subtracted at most four times
            ST_WRAP_SUB: begin
                if (r_pos >= span) begin
                    n_pos = r_pos - span;
                end else begin
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oleft  <= r_lo;
            r_oright <= r_ro;
            r_orec   <= r_rec;
            r_oloop  <= r_valid;
            r_opause <= r_paused;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.left_out     = r_oleft;
    assign o_out.right_out    = r_oright;
    assign o_out.is_recording = r_orec;
    assign o_out.has_loop     = r_oloop;
    assign o_out.is_paused    = r_opause;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(BUFFER_DEPTH),
                   "write count past depth")
    `ASSERT_IMPLIES(a_pos_in_span, i_clk, i_rst_n, r_state == ST_IDLE && r_valid,
                    r_pos < span, "read position outside loop")
    `ASSERT_IMPLIES(a_flag_excl, i_clk, i_rst_n, r_paused || r_rec,
                    !(r_rec && r_valid) && !(r_paused && !r_valid),
                    "inconsistent layer flags")
    `ASSERT_IMPLIES(a_out_from_seq, i_clk, i_rst_n, $rose(r_ov),
                    $past(r_state == ST_OUT), "result loaded outside output step")

endmodule
